@@ hdl/hex_literal_scanner_with_comments_assert.svh @@
// Assertion macros used by the scanner core, hlsc_scan.
`ifndef HEX_LITERAL_SCANNER_WITH_COMMENTS_ASSERT_SVH
`define HEX_LITERAL_SCANNER_WITH_COMMENTS_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define HLSC_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hlsc assertion failed");

// a in this cycle implies b in the next cycle
`define HLSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hlsc assertion failed");

`endif

@@ hdl/hlsc_pkg.sv @@
`timescale 1ns / 1ps
package hlsc_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_NORMAL     = 3'd0;
    localparam t_mode MODE_SLASH      = 3'd1;
    localparam t_mode MODE_LINE       = 3'd2;
    localparam t_mode MODE_BLOCK      = 3'd3;
    localparam t_mode MODE_BLOCK_STAR = 3'd4;
    localparam t_mode MODE_ZERO       = 3'd5;
    localparam t_mode MODE_HEX        = 3'd6;

    localparam t_status STAT_STORED   = 2'd0;
    localparam t_status STAT_OVERFLOW = 2'd1;
    localparam t_status STAT_FULL     = 2'd2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [15:0] CAPACITY_RST = 16'hFFFF;

    typedef struct packed {
        logic        valid;
        logic [31:0] word_value;
        logic [15:0] word_index;
        t_status     status;
    } t_result;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F) ||
               (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] lo;
        lo = c[3:0];
        return (c >= CH_UP_A) ? lo + 4'd9 : lo;
    endfunction

endpackage

@@ hdl/hlsc_if.sv @@
`timescale 1ns / 1ps
interface hlsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface hlsc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_value;
    logic [15:0] word_index;
    logic [1:0]  status;

    modport source (output valid, word_value, word_index, status, input ready);
    modport sink (input valid, word_value, word_index, status, output ready);
endinterface

@@ hdl/hlsc_scan.sv @@
`timescale 1ns / 1ps
`include "hex_literal_scanner_with_comments_assert.svh"
module hlsc_scan
    import hlsc_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_xfer,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_capacity,
    output t_result     o_res
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_DIGITS + 1);

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_acc, n_acc;
    logic [15:0]      r_wr_idx, n_wr_idx;
    t_result          res;

    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_wr_idx = r_wr_idx;
        res      = '0;
        res.word_index = r_wr_idx;

        unique case (r_mode)
            MODE_SLASH: begin
                if (i_byte == CH_SLASH)
                    n_mode = MODE_LINE;
                else if (i_byte == CH_STAR)
                    n_mode = MODE_BLOCK;
                else if (i_byte == CH_ZERO)
                    n_mode = MODE_ZERO;
                else
                    n_mode = MODE_NORMAL;
            end
            MODE_LINE: begin
                if (i_byte == CH_LF || i_byte == CH_CR)
                    n_mode = MODE_NORMAL;
            end
            MODE_BLOCK: begin
                if (i_byte == CH_STAR)
                    n_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                n_mode = (i_byte == CH_SLASH) ? MODE_NORMAL : MODE_BLOCK;
            end
            MODE_ZERO: begin
                if (i_byte == CH_LO_X || i_byte == CH_UP_X) begin
                    n_mode = MODE_HEX;
                    n_cnt  = '0;
                    n_acc  = '0;
                end else begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (is_hex(i_byte)) begin
                    if (r_cnt < CNT_MAX) begin
                        n_acc = {r_acc[27:0], hex_value(i_byte)};
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_cnt = CNT_OVER;
                    end
                end else begin
                    // terminator is consumed, literal closes
                    if (r_cnt > CNT_MAX) begin
                        res.valid  = 1'b1;
                        res.status = STAT_OVERFLOW;
                    end else if (r_cnt != '0) begin
                        res.valid = 1'b1;
                        if (r_wr_idx >= i_capacity) begin
                            res.status = STAT_FULL;
                        end else begin
                            res.status     = STAT_STORED;
                            res.word_value = r_acc;
                            n_wr_idx       = r_wr_idx + 16'd1;
                        end
                    end
                    n_mode = MODE_NORMAL;
                    n_cnt  = '0;
                    n_acc  = '0;
                end
            end
            default: begin
                if (i_byte == CH_SLASH)
                    n_mode = MODE_SLASH;
                else if (i_byte == CH_ZERO)
                    n_mode = MODE_ZERO;
                else
                    n_mode = MODE_NORMAL;
            end
        endcase

        if (i_last) begin
            n_mode   = MODE_NORMAL;
            n_cnt    = '0;
            n_acc    = '0;
            n_wr_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_wr_idx <= '0;
        end else if (i_xfer) begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_wr_idx <= n_wr_idx;
        end
    end

    always_comb begin
        o_res       = res;
        o_res.valid = res.valid & i_xfer;
    end

    `HLSC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_xfer && i_last, r_mode == MODE_NORMAL && r_wr_idx == '0 && r_cnt == '0)
    `HLSC_ASSERT_NEXT(a_store_advances, i_clk, i_rst_n, o_res.valid && o_res.status == STAT_STORED && !i_last, r_wr_idx == $past(r_wr_idx) + 16'd1)
    `HLSC_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_OVER)
    `HLSC_ASSERT_NOW(a_idle_literal, i_clk, i_rst_n, r_mode != MODE_HEX, r_cnt == '0 && r_acc == '0)

endmodule

@@ hdl/hex_literal_scanner_with_comments.sv @@
// A result is registered at the byte transfer that closes its literal and is presented in the next cycle.
// Throughput: one byte per cycle while the input is ready; the scan state and result register update in one pass.
// The input stays ready while the result register is empty or being drained.
// Reset (synchronous, active low): normal text mode, write index 0, capacity 65535,
// no result pending.
`timescale 1ns / 1ps
module hex_literal_scanner_with_comments
    import hlsc_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    hlsc_in_if.sink     i_in,
    hlsc_out_if.source  o_out
);

    logic [15:0] r_capacity;
    logic        r_out_valid;
    logic [31:0] r_word_value;
    logic [15:0] r_word_index;
    t_status     r_status;
    logic        in_xfer;
    t_result     res;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    hlsc_scan #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_xfer     (in_xfer),
        .i_byte     (i_in.text_byte),
        .i_last     (i_in.end_of_text),
        .i_capacity (r_capacity),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_word_value <= res.word_value;
            r_word_index <= res.word_index;
            r_status     <= res.status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.word_value = r_word_value;
    assign o_out.word_index = r_word_index;
    assign o_out.status     = r_status;

endmodule

@@ bench/hex_literal_scanner_with_comments_tb.sv @@
`timescale 1ns / 1ps
module hex_literal_scanner_with_comments_tb
    import hlsc_pkg::*;
();

    localparam int MAX_DIG    = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD  = 200;
    localparam int PHASE_BYTES = 80;
    localparam int RAND_PHASES = 7;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_item;

    typedef struct packed {
        logic [31:0] wval;
        logic [15:0] wslot;
        t_status     wstat;
    } t_word_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    hlsc_in_if  in_if ();
    hlsc_out_if out_if ();

    hex_literal_scanner_with_comments #(
        .MAX_DIGITS(MAX_DIG)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (in_if),
        .o_out        (out_if)
    );

    t_text_item   pending_bytes[$];
    t_word_result expected_words[$];

    // scanner state as predicted
    t_mode       scan_state;
    logic [3:0]  digit_cnt;
    logic [31:0] acc_word;
    logic [15:0] next_slot;
    logic [15:0] cap_words;

    int error_count   = 0;
    int results_seen  = 0;
    int stored_seen   = 0;
    int overflow_seen = 0;
    int full_seen     = 0;
    int bytes_sent    = 0;
    int bytes_queued  = 0;
    int texts_built   = 0;
    int cap_settings  = 0;
    int send_gap      = 0;
    int recv_hold     = 0;
    bit idle_on       = 1'b1;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.text_byte   = '0;
        in_if.end_of_text = 1'b0;
        out_if.ready      = 1'b0;
    end

    function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = 4'(c - CH_LO_A + 8'd10);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = 4'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_literal();
        scan_state = MODE_NORMAL;
        digit_cnt  = '0;
        acc_word   = '0;
    endfunction

    function automatic t_mode plain_text_mode(input logic [7:0] c);
        if (c == CH_SLASH) return MODE_SLASH;
        if (c == CH_ZERO) return MODE_ZERO;
        return MODE_NORMAL;
    endfunction

    // advance the predicted scanner by one byte, queue any word it produces
    function automatic void scan_text_byte(input logic [7:0] c, input logic last);
        t_word_result r;
        logic [3:0]   nib;
        logic         hx;
        hx = hex_digit(c, nib);
        case (scan_state)
            MODE_SLASH: begin
                if (c == CH_SLASH) scan_state = MODE_LINE;
                else if (c == CH_STAR) scan_state = MODE_BLOCK;
                else scan_state = plain_text_mode(c);
            end
            MODE_LINE: begin
                if (c == CH_LF || c == CH_CR) scan_state = MODE_NORMAL;
            end
            MODE_BLOCK: begin
                if (c == CH_STAR) scan_state = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                // a second star drops the close candidate
                scan_state = (c == CH_SLASH) ? MODE_NORMAL : MODE_BLOCK;
            end
            MODE_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    scan_state = MODE_HEX;
                    digit_cnt  = '0;
                    acc_word   = '0;
                end else begin
                    scan_state = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (hx) begin
                    if (digit_cnt < MAX_DIG) begin
                        acc_word  = {acc_word[27:0], nib};
                        digit_cnt = digit_cnt + 4'd1;
                    end else begin
                        digit_cnt = 4'(MAX_DIG + 1);
                    end
                end else begin
                    if (digit_cnt > MAX_DIG) begin
                        r.wval  = '0;
                        r.wslot = next_slot;
                        r.wstat = STAT_OVERFLOW;
                        expected_words.push_back(r);
                    end else if (digit_cnt != 0) begin
                        r.wslot = next_slot;
                        if (next_slot >= cap_words) begin
                            r.wval  = '0;
                            r.wstat = STAT_FULL;
                        end else begin
                            r.wval    = acc_word;
                            r.wstat   = STAT_STORED;
                            next_slot = next_slot + 16'd1;
                        end
                        expected_words.push_back(r);
                    end
                    clear_literal();
                end
            end
            default: scan_state = plain_text_mode(c);
        endcase
        if (last) begin
            clear_literal();
            next_slot = '0;
        end
    endfunction

    // source side
    always @(posedge i_clk) begin
        t_text_item nxt;
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.text_byte   <= '0;
            in_if.end_of_text <= 1'b0;
            send_gap  = 0;
            cap_words = CAPACITY_RST;
            next_slot = '0;
            clear_literal();
        end else begin
            if (in_if.valid && in_if.ready) begin
                scan_text_byte(in_if.text_byte, in_if.end_of_text);
                bytes_sent++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    in_if.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    in_if.valid <= 1'b0;
                end else begin
                    nxt = pending_bytes.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.text_byte   <= nxt.ch;
                    in_if.end_of_text <= nxt.last;
                end
            end
        end
    end

    // sink side and checking
    always @(posedge i_clk) begin
        t_word_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result: word_value %h word_index %0d status %0d",
                           out_if.word_value, out_if.word_index, out_if.status);
                    error_count++;
                end else begin
                    want = expected_words.pop_front();
                    case (want.wstat)
                        STAT_STORED:   stored_seen++;
                        STAT_OVERFLOW: overflow_seen++;
                        default:       full_seen++;
                    endcase
                    if (out_if.word_value !== want.wval) begin
                        $error("word_value: expected %h, actual %h", want.wval, out_if.word_value);
                        error_count++;
                    end
                    if (out_if.word_index !== want.wslot) begin
                        $error("word_index: expected %0d, actual %0d",
                               want.wslot, out_if.word_index);
                        error_count++;
                    end
                    if (out_if.status !== want.wstat) begin
                        $error("status: expected %0d, actual %0d", want.wstat, out_if.status);
                        error_count++;
                    end
                end
                // long hold-off so the result register backs up into the input
                if (results_seen == 20 || results_seen == 60) recv_hold = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                recv_hold = $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void push_byte(input logic [7:0] c);
        t_text_item t;
        t.ch   = c;
        t.last = 1'b0;
        pending_bytes.push_back(t);
        bytes_queued++;
    endfunction

    function automatic void push_string(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void mark_end();
        t_text_item t;
        t = pending_bytes.pop_back();
        t.last = 1'b1;
        pending_bytes.push_back(t);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        if ($urandom_range(0, 1)) return CH_LO_A + 8'(v) - 8'd10;
        return CH_UP_A + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        logic [3:0] nib;
        case ($urandom_range(0, 5))
            0: c = CH_LF;
            1: c = CH_CR;
            2: c = CH_SLASH;
            3: c = 8'h20;
            default: begin
                do c = 8'($urandom_range(0, 255)); while (hex_digit(c, nib));
            end
        endcase
        return c;
    endfunction

    function automatic void add_literal(input bit open_end);
        int pick;
        int ndig;
        push_byte(CH_ZERO);
        push_byte($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        pick = $urandom_range(0, 9);
        if (pick == 0) ndig = 0;
        else if (pick == 1) ndig = $urandom_range(MAX_DIG + 1, MAX_DIG + 4);
        else ndig = $urandom_range(1, MAX_DIG);
        for (int i = 0; i < ndig; i++) push_byte(hex_char(4'($urandom_range(0, 15))));
        if (!open_end) push_byte(pick_terminator());
    endfunction

    function automatic logic [7:0] comment_char();
        case ($urandom_range(0, 5))
            0: return CH_STAR;
            1: return CH_SLASH;
            2: return CH_ZERO;
            3: return CH_LO_X;
            4: return CH_LO_A;
            default: return 8'h20;
        endcase
    endfunction

    function automatic void add_segment();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            add_literal(1'b0);
        end else if (pick < 65) begin
            push_string("//");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) push_byte(comment_char());
            push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        end else if (pick < 75) begin
            push_string("/*");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) push_byte(comment_char());
            push_string("*/");
        end else if (pick < 82) begin
            push_byte(CH_ZERO);
            push_byte(8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_byte(CH_SLASH);
            push_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_text();
        int nseg;
        nseg = $urandom_range(2, 8);
        for (int i = 0; i < nseg; i++) add_segment();
        // sometimes the text ends inside a literal, which must be dropped
        if ($urandom_range(0, 9) == 0) add_literal(1'b1);
        mark_end();
        texts_built++;
    endfunction

    task automatic write_capacity(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_words = v;
        cap_settings++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_if.valid || expected_words.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int start;
        logic [15:0] cap;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset capacity: widest literal, slash as terminator, overflow,
        // bare prefix, literal left open at end of text
        push_string("0xFFFFFFFF/0x123456789;0x;0Xa");
        mark_end();
        wait_idle();

        // capacity 1: zero without x, stray slash, array full,
        // star run in block comment, bare prefix ended by a slash
        write_capacity(16'd1);
        push_string("00x1 /a0x0 0x5 /***/0x1 */0x//0x2\nZ");
        mark_end();
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: cap = 16'hFFFF;
                1: cap = 16'd1;
                2: cap = 16'($urandom_range(2, 4));
                3: cap = 16'($urandom_range(1, 65535));
                4: cap = 16'd2;
                5: cap = 16'($urandom_range(1, 16));
                default: cap = 16'd1;
            endcase
            write_capacity(cap);
            if (p == RAND_PHASES - 1) idle_on = 1'b0;
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES) add_text();
            wait_idle();
        end
        repeat (6) @(negedge i_clk);

        $display("%0d bytes in %0d texts over %0d capacity settings", bytes_sent, texts_built,
                 cap_settings);
        $display("%0d words checked: %0d stored, %0d overflow, %0d full", results_seen,
                 stored_seen, overflow_seen, full_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hlsc_pkg.sv
hdl/hlsc_if.sv
hdl/hlsc_scan.sv
hdl/hex_literal_scanner_with_comments.sv
bench/hex_literal_scanner_with_comments_tb.sv
